// ===== hdl/bscf_pkg.sv =====
// ----------------------------------------------------------------------------
// bscf_pkg
// shared types, constants and functions of the byte-stuffing crc-16 framer
// ----------------------------------------------------------------------------
package bscf_pkg;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  // worst case: flag, stuffed data, stuffed crc high, stuffed crc low, flag
  localparam int unsigned MaxOut   = 8;
  localparam int unsigned CntW     = $clog2(MaxOut + 1);
  localparam int unsigned IdxW     = $clog2(MaxOut);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // expansion of one input item, first line byte at index cnt-1
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   close;
    logic [15:0]            crc;
  } expand_t;

  function automatic logic is_special(logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // appends one byte, escaped if needed, at the low end of the list
  function automatic logic [MaxOut*8-1:0] push_stuffed(logic [MaxOut*8-1:0] v,
                                                       logic [7:0] b);
    if (is_special(b)) begin
      return {v[MaxOut*8-17:0], EscByte, b ^ EscXor};
    end
    return {v[MaxOut*8-9:0], b};
  endfunction

endpackage

// ===== hdl/bscf_expand.sv =====
// ----------------------------------------------------------------------------
// bscf_expand
// turns one payload byte into its line bytes and the updated crc (0xFFFF after a last byte)
// ----------------------------------------------------------------------------
module bscf_expand (
  input  bscf_pkg::in_item_t item_i,
  input  logic               in_frame_i,
  input  logic [15:0]        crc_i,
  output bscf_pkg::expand_t  exp_o
);

  logic [bscf_pkg::MaxOut*8-1:0] vec;
  logic [15:0]                   crc_n;
  logic [bscf_pkg::CntW-1:0]     n;

  always_comb begin
    crc_n = bscf_pkg::crc_update(crc_i, item_i.data_byte);
    vec   = '0;
    n     = '0;
    if (!in_frame_i) begin
      vec = {vec[bscf_pkg::MaxOut*8-9:0], bscf_pkg::FlagByte};
      n   = n + bscf_pkg::CntW'(1);
    end
    vec = bscf_pkg::push_stuffed(vec, item_i.data_byte);
    n   = n + bscf_pkg::CntW'(1) + bscf_pkg::CntW'(bscf_pkg::is_special(item_i.data_byte));
    if (item_i.last_byte) begin
      vec = bscf_pkg::push_stuffed(vec, crc_n[15:8]);
      vec = bscf_pkg::push_stuffed(vec, crc_n[7:0]);
      vec = {vec[bscf_pkg::MaxOut*8-9:0], bscf_pkg::FlagByte};
      n   = n + bscf_pkg::CntW'(3)
              + bscf_pkg::CntW'(bscf_pkg::is_special(crc_n[15:8]))
              + bscf_pkg::CntW'(bscf_pkg::is_special(crc_n[7:0]));
    end
  end

  assign exp_o.bytes = vec;
  assign exp_o.cnt   = n;
  assign exp_o.close = item_i.last_byte;
  assign exp_o.crc   = item_i.last_byte ? bscf_pkg::CrcInit : crc_n;

endmodule

// ===== hdl/byte_stuffed_crc16_framer.sv =====
// ----------------------------------------------------------------------------
// byte_stuffed_crc16_framer
// hdlc-style framer: opening flag, escaped payload, escaped crc-16, closing flag
// ----------------------------------------------------------------------------
// path: an input item is held in the input register, expanded, and written to
//   the result buffer, from which its first line byte is offered
// throughput: one line byte per cycle while out_ready_i is high; an input item
//   occupies the output for as many line bytes as it causes (1 to 8, typically 1 or 2)
// the input register refills while the last byte of the previous item waits
// reset (async, active low): no frame open, crc 0xFFFF, both stages empty
// ----------------------------------------------------------------------------
module byte_stuffed_crc16_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bscf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bscf_pkg::out_item_t out_item_o
);

  // input register
  logic                in_vld_q, in_vld_d;
  bscf_pkg::in_item_t  in_q;

  // framing state
  logic                in_frame_q, in_frame_d;
  logic [15:0]         crc_q, crc_d;

  // result buffer, drained from index cnt-1 down to 0
  logic [bscf_pkg::MaxOut-1:0][7:0] buf_q;
  logic [bscf_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             close_q;

  bscf_pkg::expand_t   exp;
  logic                in_xfer, out_xfer, load;
  logic [bscf_pkg::CntW-1:0] rd_idx;

  bscf_expand u_expand (
    .item_i     (in_q),
    .in_frame_i (in_frame_q),
    .crc_i      (crc_q),
    .exp_o      (exp)
  );

  // output side
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign rd_idx      = cnt_q - bscf_pkg::CntW'(1);
  assign out_item_o.out_byte  = buf_q[rd_idx[bscf_pkg::IdxW-1:0]];
  assign out_item_o.run_last  = (cnt_q == bscf_pkg::CntW'(1));
  assign out_item_o.frame_end = (cnt_q == bscf_pkg::CntW'(1)) && close_q;

  // the buffer takes a new expansion when empty or when its final byte leaves
  assign load = in_vld_q && ((cnt_q == '0) || ((cnt_q == bscf_pkg::CntW'(1)) && out_ready_i));

  // input register frees up in the same cycle it hands over
  assign in_ready_o = !in_vld_q || load;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    if (load) begin
      cnt_d      = exp.cnt;
      in_frame_d = !exp.close;
      crc_d      = exp.crc;
    end else if (out_xfer) begin
      cnt_d = cnt_q - bscf_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      cnt_q      <= '0;
      in_frame_q <= 1'b0;
      crc_q      <= bscf_pkg::CrcInit;
    end else begin
      in_vld_q   <= in_vld_d;
      cnt_q      <= cnt_d;
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
    if (load) begin
      buf_q   <= exp.bytes;
      close_q <= exp.close;
    end
  end

  // checks
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bscf_pkg::CntW'(bscf_pkg::MaxOut))
    else $error("result count beyond buffer depth");

  a_crc_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> crc_q == bscf_pkg::CrcInit)
    else $error("crc not at initial value outside a frame");

  a_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.run_last)
    else $error("closing flag not on the final byte of its item");

  a_open_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !in_frame_q |=> out_valid_o && out_item_o.out_byte == bscf_pkg::FlagByte)
    else $error("frame opened without flag");

  a_no_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == '0) || out_xfer)
    else $error("buffer overwritten with bytes pending");

endmodule
